@@ rtl/rmts_pkg.sv @@
`default_nettype none

package rmts_pkg;

    localparam int JOB_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    localparam int ACTIVE_W   = 5;
    localparam int PORT_TIME_W = 16;
    localparam int PORT_SLOT_W = 4;
    localparam int ID_W       = 8;
    localparam int IDS_W      = 2 * ID_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_JOBS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCHED_LEN   = CFG_IDX_W'(1);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [2:0] {
        STAT_LOADED = 3'd0,
        STAT_RAN    = 3'd1,
        STAT_IDLE   = 3'd2,
        STAT_MISS   = 3'd3,
        STAT_DONE   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DELIVER
    } state_t;

    // flags carried along the cell row with the scan record
    typedef struct packed {
        logic found;
        logic miss;
        logic prev_hit;
    } scan_flags_t;

    // broadcast write command to the cells
    typedef struct packed {
        logic load;
        logic run;
    } cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/rate_monotonic_tick_scheduler.sv @@
// Rate-monotonic tick scheduler.
// Input stream (s_*): each request is either a job load (s_tuser = 0) that
// writes one slot of the job table, or a tick (s_tuser = 1) that advances
// the schedule by one time unit. Every request yields exactly one result on
// the output stream (m_*), with the result kind on m_tuser.
// Configuration: cfg_wr_en writes active_jobs (index 0) or schedule_length
// (index 1); write only while no request is in flight.
// Flow: a load or a finished tick is captured in the holding register on
// acceptance. A scheduling tick walks its record through the row of
// JOB_SLOTS cells, one cell per cycle, and is captured once the scan is
// done. A result moves on to the output register when that is empty or
// being read. One request is processed at a time.
// Reset (aresetn low, synchronous) clears time, halt, previous choice,
// configuration and run stamps; job fields hold no value until loaded.
// A result sits in the output register until m_tready; the next request is
// accepted meanwhile, and its result waits in a holding register, so a
// stalled receiver stalls the input only after one request.
`default_nettype none

module rate_monotonic_tick_scheduler
    import rmts_pkg::*;
#(
    parameter int JOB_SLOTS = JOB_SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // tdata: slot[3:0], arrival_time[19:4], job_period[35:20],
    //        deadline_time[51:36], budget[67:52], job_number[75:68],
    //        task_number[83:76], zero pad[87:84]
    input  wire logic [87:0]           s_tdata,
    // tuser: func
    input  wire logic                  s_tuser,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // tdata: tick_time[15:0], chosen_slot[19:16], chosen_job[27:20],
    //        chosen_task[35:28], switched[36], zero pad[39:37]
    output logic [39:0]                m_tdata,
    // tuser: status
    output logic [2:0]                 m_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int SLOT_W = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
    localparam int CNT_W  = $clog2(JOB_SLOTS + 1);

    state_t state_reg;
    state_t state_next;

    logic [ACTIVE_W-1:0]    active_jobs_reg;
    logic [PORT_TIME_W-1:0] sched_len_reg;
    logic [TIME_BITS-1:0]   current_tick_reg;
    logic                   prev_valid_reg;
    logic [SLOT_W-1:0]      prev_slot_reg;
    logic                   halted_reg;
    logic [CNT_W-1:0]       scan_cnt_reg;

    // pending result
    status_t                res_status_reg;
    logic [PORT_TIME_W-1:0] res_tick_reg;
    logic [PORT_SLOT_W-1:0] res_slot_reg;
    logic [IDS_W-1:0]       res_ids_reg;
    logic                   res_sw_reg;
    status_t                res_status_next;
    logic [PORT_SLOT_W-1:0] res_slot_next;
    logic [IDS_W-1:0]       res_ids_next;
    logic                   res_sw_next;

    // output register
    status_t                out_status_reg;
    logic [PORT_TIME_W-1:0] out_tick_reg;
    logic [PORT_SLOT_W-1:0] out_slot_reg;
    logic [IDS_W-1:0]       out_ids_reg;
    logic                   out_sw_reg;
    logic                   m_tvalid_reg;

    logic                 in_fire;
    logic                 is_load;
    logic                 sched_over;
    logic                 scan_done;
    logic                 finish;
    logic                 deliver_fire;
    logic                 res_load;
    logic [SLOT_W-1:0]    ld_slot;
    logic [TIME_BITS:0]   run_stamp;
    cell_cmd_t            cmd;
    logic [SLOT_W-1:0]    cmd_slot;
    logic                 pick_prev;
    logic [SLOT_W-1:0]    pick_slot;
    logic [IDS_W-1:0]     pick_ids;

    // scan record links; entry 0 is the empty record entering the row
    scan_flags_t          chain_flags  [JOB_SLOTS+1];
    logic [TIME_BITS-1:0] chain_period [JOB_SLOTS+1];
    logic [TIME_BITS:0]   chain_stamp  [JOB_SLOTS+1];
    logic [SLOT_W-1:0]    chain_slot   [JOB_SLOTS+1];
    logic [IDS_W-1:0]     chain_ids    [JOB_SLOTS+1];
    logic [SLOT_W-1:0]    chain_mslot  [JOB_SLOTS+1];
    logic [IDS_W-1:0]     chain_mids   [JOB_SLOTS+1];
    logic [TIME_BITS-1:0] chain_pperiod[JOB_SLOTS+1];
    logic [IDS_W-1:0]     chain_pids   [JOB_SLOTS+1];

    assign chain_flags[0]   = '0;
    assign chain_period[0]  = '0;
    assign chain_stamp[0]   = '0;
    assign chain_slot[0]    = '0;
    assign chain_ids[0]     = '0;
    assign chain_mslot[0]   = '0;
    assign chain_mids[0]    = '0;
    assign chain_pperiod[0] = '0;
    assign chain_pids[0]    = '0;

    for (genvar g = 0; g < JOB_SLOTS; g++) begin : g_cell
        rmts_cell #(
            .CELL_IDX (g),
            .TIME_BITS(TIME_BITS),
            .SLOT_W   (SLOT_W)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .slots_used     (active_jobs_reg),
            .cur_tick       (current_tick_reg),
            .prev_valid     (prev_valid_reg),
            .prev_slot      (prev_slot_reg),
            .cmd            (cmd),
            .cmd_slot       (cmd_slot),
            .ld_ready       (TIME_BITS'(s_tdata[19:4])),
            .ld_period      (TIME_BITS'(s_tdata[35:20])),
            .ld_deadline    (TIME_BITS'(s_tdata[51:36])),
            .ld_budget      (TIME_BITS'(s_tdata[67:52])),
            .ld_ids         (s_tdata[83:68]),
            .run_stamp      (run_stamp),
            .flags_in       (chain_flags[g]),
            .best_period_in (chain_period[g]),
            .best_stamp_in  (chain_stamp[g]),
            .best_slot_in   (chain_slot[g]),
            .best_ids_in    (chain_ids[g]),
            .miss_slot_in   (chain_mslot[g]),
            .miss_ids_in    (chain_mids[g]),
            .prev_period_in (chain_pperiod[g]),
            .prev_ids_in    (chain_pids[g]),
            .flags_out      (chain_flags[g+1]),
            .best_period_out(chain_period[g+1]),
            .best_stamp_out (chain_stamp[g+1]),
            .best_slot_out  (chain_slot[g+1]),
            .best_ids_out   (chain_ids[g+1]),
            .miss_slot_out  (chain_mslot[g+1]),
            .miss_ids_out   (chain_mids[g+1]),
            .prev_period_out(chain_pperiod[g+1]),
            .prev_ids_out   (chain_pids[g+1])
        );
    end

    // load slot wraps modulo the table size
    always_comb begin
        ld_slot = '0;
        for (int k = 0; k < 16; k++) begin
            if (s_tdata[3:0] == PORT_SLOT_W'(k)) begin
                ld_slot = SLOT_W'(k % JOB_SLOTS);
            end
        end
    end

    assign is_load    = (s_tuser == FUNC_LOAD);
    assign sched_over = halted_reg ||
                        (33'(current_tick_reg) >= 33'(sched_len_reg));
    assign scan_done  = (scan_cnt_reg == CNT_W'(JOB_SLOTS));
    assign run_stamp  = {1'b0, current_tick_reg} + (TIME_BITS + 1)'(1);

    // previous job keeps running when it ties on the best period
    assign pick_prev = prev_valid_reg && chain_flags[JOB_SLOTS].prev_hit &&
                       (chain_pperiod[JOB_SLOTS] == chain_period[JOB_SLOTS]);
    assign pick_slot = pick_prev ? prev_slot_reg : chain_slot[JOB_SLOTS];
    assign pick_ids  = pick_prev ? chain_pids[JOB_SLOTS] : chain_ids[JOB_SLOTS];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (is_load || sched_over) ? ST_DELIVER : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        finish       = (state_reg == ST_SCAN) && scan_done;
        deliver_fire = (state_reg == ST_DELIVER) && (!m_tvalid_reg || m_tready);
        in_fire      = s_tvalid && s_tready;
        res_load     = in_fire || finish;
        cmd.load     = in_fire && is_load;
        cmd.run      = finish && !chain_flags[JOB_SLOTS].miss &&
                       chain_flags[JOB_SLOTS].found;
        cmd_slot     = finish ? pick_slot : ld_slot;
    end

    always_comb begin
        res_status_next = STAT_DONE;
        res_slot_next   = '0;
        res_ids_next    = '0;
        res_sw_next     = 1'b0;
        if (!finish) begin
            if (is_load) begin
                res_status_next = STAT_LOADED;
                res_slot_next   = PORT_SLOT_W'(ld_slot);
                res_ids_next    = s_tdata[83:68];
            end
        end else if (chain_flags[JOB_SLOTS].miss) begin
            res_status_next = STAT_MISS;
            res_slot_next   = PORT_SLOT_W'(chain_mslot[JOB_SLOTS]);
            res_ids_next    = chain_mids[JOB_SLOTS];
        end else if (chain_flags[JOB_SLOTS].found) begin
            res_status_next = STAT_RAN;
            res_slot_next   = PORT_SLOT_W'(pick_slot);
            res_ids_next    = pick_ids;
            res_sw_next     = !prev_valid_reg || (pick_slot != prev_slot_reg);
        end else begin
            res_status_next = STAT_IDLE;
            res_sw_next     = prev_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            active_jobs_reg  <= '0;
            sched_len_reg    <= '0;
            current_tick_reg <= '0;
            prev_valid_reg   <= 1'b0;
            prev_slot_reg    <= '0;
            halted_reg       <= 1'b0;
            scan_cnt_reg     <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_ACTIVE_JOBS: active_jobs_reg <= cfg_wr_data[ACTIVE_W-1:0];
                    REG_SCHED_LEN:   sched_len_reg   <= cfg_wr_data;
                    default: ;
                endcase
            end
            scan_cnt_reg <= (state_reg == ST_SCAN) ? scan_cnt_reg + CNT_W'(1) : '0;
            if (finish) begin
                if (chain_flags[JOB_SLOTS].miss) begin
                    halted_reg <= 1'b1;
                end else begin
                    current_tick_reg <= current_tick_reg + TIME_BITS'(1);
                    prev_valid_reg   <= chain_flags[JOB_SLOTS].found;
                    prev_slot_reg    <= chain_flags[JOB_SLOTS].found ? pick_slot : '0;
                end
            end
            if (deliver_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_status_reg <= res_status_next;
            res_tick_reg   <= PORT_TIME_W'(current_tick_reg);
            res_slot_reg   <= res_slot_next;
            res_ids_reg    <= res_ids_next;
            res_sw_reg     <= res_sw_next;
        end
        if (deliver_fire) begin
            out_status_reg <= res_status_reg;
            out_tick_reg   <= res_tick_reg;
            out_slot_reg   <= res_slot_reg;
            out_ids_reg    <= res_ids_reg;
            out_sw_reg     <= res_sw_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_sw_reg, out_ids_reg, out_slot_reg, out_tick_reg};

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt flag dropped without reset");

    a_tick_at_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(current_tick_reg) |-> $past(state_reg == ST_SCAN))
        else $error("tick counter moved outside a scan finish");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg <= CNT_W'(JOB_SLOTS)))
        else $error("scan ran past the cell row");

    a_no_run_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && chain_flags[JOB_SLOTS].miss) |=> $stable(current_tick_reg))
        else $error("tick advanced on a deadline miss");
`endif

endmodule

`default_nettype wire

@@ rtl/rmts_cell.sv @@
`default_nettype none

module rmts_cell
    import rmts_pkg::*;
#(
    parameter int unsigned CELL_IDX  = 0,
    parameter int          TIME_BITS = TIME_BITS_DEF,
    parameter int          SLOT_W    = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [ACTIVE_W-1:0]  slots_used,
    input  wire logic [TIME_BITS-1:0] cur_tick,
    input  wire logic                 prev_valid,
    input  wire logic [SLOT_W-1:0]    prev_slot,
    input  wire cell_cmd_t            cmd,
    input  wire logic [SLOT_W-1:0]    cmd_slot,
    input  wire logic [TIME_BITS-1:0] ld_ready,
    input  wire logic [TIME_BITS-1:0] ld_period,
    input  wire logic [TIME_BITS-1:0] ld_deadline,
    input  wire logic [TIME_BITS-1:0] ld_budget,
    input  wire logic [IDS_W-1:0]     ld_ids,
    input  wire logic [TIME_BITS:0]   run_stamp,
    input  wire scan_flags_t          flags_in,
    input  wire logic [TIME_BITS-1:0] best_period_in,
    input  wire logic [TIME_BITS:0]   best_stamp_in,
    input  wire logic [SLOT_W-1:0]    best_slot_in,
    input  wire logic [IDS_W-1:0]     best_ids_in,
    input  wire logic [SLOT_W-1:0]    miss_slot_in,
    input  wire logic [IDS_W-1:0]     miss_ids_in,
    input  wire logic [TIME_BITS-1:0] prev_period_in,
    input  wire logic [IDS_W-1:0]     prev_ids_in,
    output scan_flags_t               flags_out,
    output logic      [TIME_BITS-1:0] best_period_out,
    output logic      [TIME_BITS:0]   best_stamp_out,
    output logic      [SLOT_W-1:0]    best_slot_out,
    output logic      [IDS_W-1:0]     best_ids_out,
    output logic      [SLOT_W-1:0]    miss_slot_out,
    output logic      [IDS_W-1:0]     miss_ids_out,
    output logic      [TIME_BITS-1:0] prev_period_out,
    output logic      [IDS_W-1:0]     prev_ids_out
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_IDX);

    logic [TIME_BITS-1:0] ready_reg;
    logic [TIME_BITS-1:0] period_reg;
    logic [TIME_BITS-1:0] deadline_reg;
    logic [TIME_BITS-1:0] budget_reg;
    logic [TIME_BITS:0]   stamp_reg;
    logic [IDS_W-1:0]     ids_reg;

    logic        hit_slot;
    logic        in_use;
    logic        elig_raw;
    logic        elig;
    logic        late;
    logic        take;

    scan_flags_t          flags_next;
    logic [TIME_BITS-1:0] best_period_next;
    logic [TIME_BITS:0]   best_stamp_next;
    logic [SLOT_W-1:0]    best_slot_next;
    logic [IDS_W-1:0]     best_ids_next;
    logic [SLOT_W-1:0]    miss_slot_next;
    logic [IDS_W-1:0]     miss_ids_next;
    logic [TIME_BITS-1:0] prev_period_next;
    logic [IDS_W-1:0]     prev_ids_next;

    assign hit_slot = (cmd_slot == MY_SLOT);

    always_ff @(posedge aclk) begin
        if (cmd.load && hit_slot) begin
            ready_reg    <= ld_ready;
            period_reg   <= ld_period;
            deadline_reg <= ld_deadline;
            budget_reg   <= ld_budget;
            ids_reg      <= ld_ids;
        end else if (cmd.run && hit_slot) begin
            budget_reg <= budget_reg - TIME_BITS'(1);
        end
    end

    // zero stamp means never run
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stamp_reg <= '0;
        end else if (cmd.load && hit_slot) begin
            stamp_reg <= '0;
        end else if (cmd.run && hit_slot) begin
            stamp_reg <= run_stamp;
        end
    end

    assign in_use   = (32'(slots_used) > CELL_IDX);
    assign elig_raw = (budget_reg != '0) && (ready_reg <= cur_tick);
    assign elig     = in_use && elig_raw;
    assign late     = in_use && (budget_reg != '0) && (cur_tick >= deadline_reg);
    assign take     = elig && (!flags_in.found || (period_reg < best_period_in) ||
                      ((period_reg == best_period_in) && (stamp_reg > best_stamp_in)));

    always_comb begin
        flags_next       = flags_in;
        best_period_next = best_period_in;
        best_stamp_next  = best_stamp_in;
        best_slot_next   = best_slot_in;
        best_ids_next    = best_ids_in;
        miss_slot_next   = miss_slot_in;
        miss_ids_next    = miss_ids_in;
        prev_period_next = prev_period_in;
        prev_ids_next    = prev_ids_in;
        // first late slot in index order wins
        if (late && !flags_in.miss) begin
            flags_next.miss = 1'b1;
            miss_slot_next  = MY_SLOT;
            miss_ids_next   = ids_reg;
        end
        if (take) begin
            flags_next.found = 1'b1;
            best_period_next = period_reg;
            best_stamp_next  = stamp_reg;
            best_slot_next   = MY_SLOT;
            best_ids_next    = ids_reg;
        end
        // previous job is checked regardless of the in-use count
        if (prev_valid && (prev_slot == MY_SLOT) && elig_raw) begin
            flags_next.prev_hit = 1'b1;
            prev_period_next    = period_reg;
            prev_ids_next       = ids_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_out <= '0;
        end else begin
            flags_out <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_period_out <= best_period_next;
        best_stamp_out  <= best_stamp_next;
        best_slot_out   <= best_slot_next;
        best_ids_out    <= best_ids_next;
        miss_slot_out   <= miss_slot_next;
        miss_ids_out    <= miss_ids_next;
        prev_period_out <= prev_period_next;
        prev_ids_out    <= prev_ids_next;
    end

endmodule

`default_nettype wire

@@ tb/rate_monotonic_tick_scheduler_test.sv @@
`default_nettype none

module rate_monotonic_tick_scheduler_test;
    import rmts_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic        func;
        logic [3:0]  slot;
        logic [15:0] arrival;
        logic [15:0] period;
        logic [15:0] deadline;
        logic [15:0] budget;
        logic [7:0]  job_id;
        logic [7:0]  task_id;
    } job_request_t;

    typedef struct {
        status_t     st;
        logic [15:0] tick_at;
        logic [3:0]  slot_no;
        logic [7:0]  job_no;
        logic [7:0]  task_no;
        logic        sw;
    } sched_outcome_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [87:0]           s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [39:0]           m_tdata;
    logic [2:0]            m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    rate_monotonic_tick_scheduler uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // shadow of the job table and scheduler state
    logic [15:0] ready_at [16];
    logic [15:0] job_period [16];
    logic [15:0] job_deadline [16];
    logic [15:0] budget_left [16];
    logic [16:0] run_stamp [16];
    logic [7:0]  job_tag [16];
    logic [7:0]  task_tag [16];
    logic [15:0] now_tick = '0;
    logic        had_pick = 1'b0;
    logic [3:0]  last_pick = '0;
    logic        halted = 1'b0;
    logic [4:0]  cfg_active = '0;
    logic [15:0] cfg_len = '0;

    job_request_t   request_q [$];
    sched_outcome_t outcome_q [$];
    job_request_t   cur_req;

    int mismatches = 0;
    int send_idle_pct = 19;
    int recv_idle_pct = 71;
    int gen_tick = 0;
    bit hold_on = 1'b0;
    bit hold_done = 1'b0;
    int hold_cnt = 0;
    int quiet_cycles = 0;

    function automatic bit job_ready(int i);
        return budget_left[i] != 0 && ready_at[i] <= now_tick;
    endfunction

    // next scheduler decision for one accepted request
    task automatic schedule_request(input job_request_t r);
        sched_outcome_t o;
        int n;
        int pick;
        bit found;
        bit miss;
        bit sw;
        logic [15:0] best;
        o.st = STAT_DONE;
        o.tick_at = now_tick;
        o.slot_no = '0;
        o.job_no = '0;
        o.task_no = '0;
        o.sw = 1'b0;
        if (r.func == FUNC_LOAD) begin
            ready_at[r.slot] = r.arrival;
            job_period[r.slot] = r.period;
            job_deadline[r.slot] = r.deadline;
            budget_left[r.slot] = r.budget;
            job_tag[r.slot] = r.job_id;
            task_tag[r.slot] = r.task_id;
            run_stamp[r.slot] = '0;
            o.st = STAT_LOADED;
            o.slot_no = r.slot;
            o.job_no = r.job_id;
            o.task_no = r.task_id;
        end else if (!halted && now_tick < cfg_len) begin
            n = (cfg_active > 16) ? 16 : int'(cfg_active);
            miss = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!miss && budget_left[i] != 0 && now_tick >= job_deadline[i]) begin
                    miss = 1'b1;
                    halted = 1'b1;
                    o.st = STAT_MISS;
                    o.slot_no = i[3:0];
                    o.job_no = job_tag[i];
                    o.task_no = task_tag[i];
                end
            end
            if (!miss) begin
                found = 1'b0;
                pick = 0;
                best = '0;
                for (int i = 0; i < n; i++) begin
                    if (job_ready(i)) begin
                        if (!found || job_period[i] < best) begin
                            found = 1'b1;
                            pick = i;
                            best = job_period[i];
                        end else if (job_period[i] == best &&
                                     run_stamp[i] > run_stamp[pick]) begin
                            pick = i;
                        end
                    end
                end
                // previous job keeps the processor on an equal period
                if (found && had_pick && job_ready(last_pick) &&
                    job_period[last_pick] == best)
                    pick = last_pick;
                sw = (found != had_pick) || (found && pick[3:0] != last_pick);
                if (found) begin
                    budget_left[pick] = budget_left[pick] - 16'd1;
                    run_stamp[pick] = {1'b0, now_tick} + 17'd1;
                    o.st = STAT_RAN;
                    o.slot_no = pick[3:0];
                    o.job_no = job_tag[pick];
                    o.task_no = task_tag[pick];
                end else begin
                    o.st = STAT_IDLE;
                end
                o.sw = sw;
                had_pick = found;
                last_pick = found ? pick[3:0] : 4'd0;
                now_tick = now_tick + 16'd1;
            end
        end
        outcome_q.push_back(o);
    endtask

    // sender: hold the request until taken, then advance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                schedule_request(cur_req);
            if (!s_tvalid || s_tready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = request_q.pop_front();
                    s_tdata <= {4'b0, cur_req.task_id, cur_req.job_id, cur_req.budget,
                                cur_req.deadline, cur_req.period, cur_req.arrival,
                                cur_req.slot};
                    s_tuser <= cur_req.func;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off to back up the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_on && !hold_done) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES)
                hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_result
        sched_outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (outcome_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result status %0d data %h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = outcome_q.pop_front();
                if (m_tuser !== want.st || m_tdata[15:0] !== want.tick_at ||
                    m_tdata[19:16] !== want.slot_no || m_tdata[27:20] !== want.job_no ||
                    m_tdata[35:28] !== want.task_no || m_tdata[36] !== want.sw) begin
                    mismatches++;
                    $display("%0t: expected st %0d tick %0d slot %0d job %0d task %0d sw %0b",
                             $time, want.st, want.tick_at, want.slot_no, want.job_no,
                             want.task_no, want.sw);
                    $display("%0t:   actual st %0d tick %0d slot %0d job %0d task %0d sw %0b",
                             $time, m_tuser, m_tdata[15:0], m_tdata[19:16],
                             m_tdata[27:20], m_tdata[35:28], m_tdata[36]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("rate_monotonic_tick_scheduler: mismatch");
            $finish;
        end
    end

    task automatic push_load(input int slot, input int arr, input int per, input int dl,
                             input int bud, input int jn, input int tn);
        job_request_t r;
        r.func = FUNC_LOAD;
        r.slot = slot[3:0];
        r.arrival = arr[15:0];
        r.period = per[15:0];
        r.deadline = dl[15:0];
        r.budget = bud[15:0];
        r.job_id = jn[7:0];
        r.task_id = tn[7:0];
        request_q.push_back(r);
    endtask

    task automatic push_tick();
        job_request_t r;
        r.func = FUNC_TICK;
        r.slot = 4'($urandom_range(15));
        r.arrival = 16'($urandom_range(65535));
        r.period = 16'($urandom_range(65535));
        r.deadline = 16'($urandom_range(65535));
        r.budget = 16'($urandom_range(65535));
        r.job_id = 8'($urandom_range(255));
        r.task_id = 8'($urandom_range(255));
        request_q.push_back(r);
        if (gen_tick < cfg_len)
            gen_tick++;
    endtask

    // jobs with budget get a deadline no earlier than the schedule length, so none misses
    task automatic add_random_job(input int slot);
        int arr;
        int per;
        int dl;
        int bud;
        int pick;
        pick = $urandom_range(19);
        if (pick < 5)
            bud = 0;
        else if (pick == 5)
            bud = 65535;
        else
            bud = $urandom_range(6, 1);
        dl = (bud == 0) ? int'($urandom_range(65535)) : int'($urandom_range(65535, cfg_len));
        pick = $urandom_range(9);
        if (pick < 7) begin
            arr = gen_tick + $urandom_range(12);
            if (arr > 65535)
                arr = 65535;
        end else if (pick == 7) begin
            arr = 65535;
        end else if (pick == 8) begin
            arr = $urandom_range(gen_tick);
        end else begin
            arr = $urandom_range(65535);
        end
        pick = $urandom_range(9);
        if (pick < 6)
            per = $urandom_range(4, 1);
        else if (pick < 8)
            per = $urandom_range(65535, 1);
        else if (pick == 8)
            per = 1;
        else
            per = 65535;
        push_load(slot, arr, per, dl, bud, $urandom_range(255), $urandom_range(255));
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val[15:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_ACTIVE_JOBS)
            cfg_active = val[4:0];
        else if (idx == REG_SCHED_LEN)
            cfg_len = val[15:0];
    endtask

    task automatic settle();
        do @(posedge aclk);
        while (request_q.size() != 0 || s_tvalid || outcome_q.size() != 0);
        repeat (JOB_SLOTS_DEF + 8) @(posedge aclk);
    endtask

    task automatic run_phase(input int active, input int len, input int count,
                             input int send_pct, input int recv_pct);
        settle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        reg_write(REG_ACTIVE_JOBS, active);
        reg_write(REG_SCHED_LEN, len);
        for (int s = 0; s < 16; s++)
            add_random_job(s);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 22)
                add_random_job($urandom_range(15));
            else
                push_tick();
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: finished at length zero, idle with no slots, ties and reloads
        reg_write(REG_ACTIVE_JOBS, 0);
        reg_write(REG_SCHED_LEN, 0);
        push_tick();
        settle();
        reg_write(REG_SCHED_LEN, 300);
        push_tick();
        push_load(15, 65535, 65535, 65535, 65535, 255, 255);
        push_load(0, 0, 2, 65535, 2, 1, 1);
        push_load(1, 0, 2, 65535, 3, 2, 2);
        push_load(2, 3, 1, 65535, 1, 3, 3);
        settle();
        reg_write(REG_ACTIVE_JOBS, 3);
        repeat (5) push_tick();
        push_load(0, 0, 2, 65535, 2, 8'h80, 8'h7f);
        repeat (5) push_tick();

        run_phase(16, gen_tick + 300, 430, 19, 71);
        run_phase($urandom_range(15, 2), gen_tick + 300, 430, 71, 19);
        settle();
        hold_on = 1'b1;
        run_phase(16, 65535, 430, 0, 0);

        // deadline miss: lowest missing slot reports, then the block stays halted
        settle();
        reg_write(REG_ACTIVE_JOBS, 3);
        push_load(0, 0, 1, 0, 0, 8'h10, 8'h01);
        push_load(1, 0, 1, 0, 1, 8'h11, 8'h22);
        push_load(2, 0, 1, 1, 5, 8'h12, 8'h33);
        push_tick();
        push_tick();
        add_random_job(3);
        push_tick();
        settle();

        if (mismatches == 0)
            $display("rate_monotonic_tick_scheduler: match");
        else
            $display("rate_monotonic_tick_scheduler: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
